// ----- design/rtlpm_pkg.sv -----
// shared types, constants and helper functions of the route table
package rtlpm_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IFACE_BITS    = 8;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [IFACE_BITS-1:0] iface_t;

    // operation codes of a request transaction
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2
    } opcode_t;

    // status codes of a result transaction
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_IDENTICAL = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    // one stored route: key {prefix, len} then next hop {direct, gateway, iface}
    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  len;
        logic        direct;
        logic [31:0] gateway;
        iface_t      iface;
    } route_t;

    localparam int ROUTE_W = $bits(route_t);

    // result transaction payload
    typedef struct packed {
        status_t     status;
        logic        hit;
        logic [31:0] prefix;
        logic [5:0]  len;
        logic        direct;
        logic [31:0] gateway;
        logic [7:0]  iface;
    } result_t;

    // top len bits set; lengths of 32 and above give all ones
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        len_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

    // next hop part of a route
    function automatic logic [32+IFACE_BITS:0] route_hop(input route_t r);
        route_hop = {r.direct, r.gateway, r.iface};
    endfunction

endpackage

// ----- design/rtlpm_req_if.sv -----
// request channel: add, delete or lookup transaction
interface rtlpm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic        direct;
    logic [31:0] gateway;
    logic [7:0]  out_interface;

    modport source (
        output valid, opcode, address, prefix_len, direct, gateway, out_interface,
        input  ready
    );
    modport sink (
        input  valid, opcode, address, prefix_len, direct, gateway, out_interface,
        output ready
    );
endinterface

// ----- design/rtlpm_rsp_if.sv -----
// result channel: status and matched route of one transaction
interface rtlpm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        hit;
    logic [31:0] match_prefix;
    logic [5:0]  match_len;
    logic        match_direct;
    logic [31:0] match_gateway;
    logic [7:0]  match_interface;

    modport source (
        output valid, status, hit, match_prefix, match_len, match_direct,
               match_gateway, match_interface,
        input  ready
    );
    modport sink (
        input  valid, status, hit, match_prefix, match_len, match_direct,
               match_gateway, match_interface,
        output ready
    );
endinterface

// ----- design/ipv4_route_table_lpm_core.sv -----
// ipv4 route table with exact-match add/delete and longest prefix lookup
//
//  channel  dir  handshake     content
//  req      in   valid/ready   opcode, address, prefix_len, direct, gateway, out_interface
//  rsp      out  valid/ready   status, hit, match_prefix, match_len, match_direct,
//                              match_gateway, match_interface
//
// every transaction scans all TABLE_ENTRIES slots through the single route ram port,
// one slot per cycle; the finish state loads the result register after the last slot
// is evaluated; a new request is taken only in idle, after the previous scan is through
// the result waits in an output register, so a new request is taken while it is pending;
// the final update cycle waits only if the previous result has not been taken yet
// reset clears the per-slot valid flags at once; route ram contents need no clearing
module ipv4_route_table_lpm_core (
    input  logic           clk,
    input  logic           rst_n,
    rtlpm_req_if.sink      req,
    rtlpm_rsp_if.source    rsp
);

    localparam rtlpm_pkg::idx_t LAST_IDX = rtlpm_pkg::idx_t'(rtlpm_pkg::TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // request held during the scan
    logic [1:0]        op_reg, op_next;
    logic [31:0]       addr_reg, addr_next;
    rtlpm_pkg::route_t item_reg, item_next;

    // scan pointers
    rtlpm_pkg::idx_t rd_idx_reg, rd_idx_next;
    rtlpm_pkg::idx_t pidx_reg, pidx_next;
    logic            issue_reg, issue_next;
    logic            pend_reg, pend_next;

    // scan findings
    logic              found_reg, found_next;
    rtlpm_pkg::idx_t   found_idx_reg, found_idx_next;
    rtlpm_pkg::route_t found_word_reg, found_word_next;
    logic              free_reg, free_next;
    rtlpm_pkg::idx_t   free_idx_reg, free_idx_next;
    logic              best_reg, best_next;
    rtlpm_pkg::route_t best_word_reg, best_word_next;

    logic [rtlpm_pkg::TABLE_ENTRIES-1:0] valid_reg, valid_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    rtlpm_pkg::result_t result_reg, result_next;

    // ram port
    logic                         ram_we;
    rtlpm_pkg::idx_t              ram_addr;
    rtlpm_pkg::route_t            ram_wdata;
    logic [rtlpm_pkg::ROUTE_W-1:0] ram_rdata;
    rtlpm_pkg::route_t            rd_word;

    // request decode
    logic [5:0]        req_len;
    rtlpm_pkg::route_t req_route;

    // per-slot compare
    logic slot_valid, slot_exact, slot_covers, out_free;

    rtlpm_ram #(
        .WIDTH (rtlpm_pkg::ROUTE_W),
        .DEPTH (rtlpm_pkg::TABLE_ENTRIES)
    ) u_route_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_word = rtlpm_pkg::route_t'(ram_rdata);

    // saturate length, mask prefix, drop next hop of direct routes
    always_comb
    begin
        req_len          = (req.prefix_len > 6'd32) ? 6'd32 : req.prefix_len;
        req_route.prefix = req.address & rtlpm_pkg::len_mask(req_len);
        req_route.len    = req_len;
        req_route.direct = req.direct;
        req_route.gateway = req.direct ? 32'd0 : req.gateway;
        req_route.iface  = req.direct ? '0 : rtlpm_pkg::iface_t'(req.out_interface);
    end

    // compare of the slot whose data arrives this cycle
    assign slot_valid  = valid_reg[pidx_reg];
    assign slot_exact  = slot_valid && (rd_word.prefix == item_reg.prefix)
                         && (rd_word.len == item_reg.len);
    assign slot_covers = slot_valid
                         && ((addr_reg & rtlpm_pkg::len_mask(rd_word.len)) == rd_word.prefix);
    assign out_free    = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == ST_IDLE);

    // sequencer, scan bookkeeping and final update
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        item_next       = item_reg;
        rd_idx_next     = rd_idx_reg;
        pidx_next       = pidx_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_word_next = found_word_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        best_next       = best_reg;
        best_word_next  = best_word_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        result_next     = result_reg;
        ram_we          = 1'b0;
        ram_addr        = rd_idx_reg;
        ram_wdata       = item_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.opcode;
                    addr_next   = req.address;
                    item_next   = req_route;
                    rd_idx_next = '0;
                    issue_next  = 1'b1;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    free_next   = 1'b0;
                    best_next   = 1'b0;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // issue reads
                if (issue_reg)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                end
                pend_next = issue_reg;
                pidx_next = rd_idx_reg;

                // evaluate returned slot
                if (pend_reg)
                begin
                    if (slot_exact && !found_reg)
                    begin
                        found_next      = 1'b1;
                        found_idx_next  = pidx_reg;
                        found_word_next = rd_word;
                    end
                    if (!slot_valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = pidx_reg;
                    end
                    if (slot_covers && (!best_reg || (rd_word.len > best_word_reg.len)))
                    begin
                        best_next      = 1'b1;
                        best_word_next = rd_word;
                    end
                    if (pidx_reg == LAST_IDX)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    result_next        = '0;
                    result_next.status = rtlpm_pkg::STATUS_NOT_FOUND;
                    case (op_reg)
                        rtlpm_pkg::OP_ADD:
                        begin
                            if (found_reg)
                            begin
                                if (rtlpm_pkg::route_hop(found_word_reg)
                                    == rtlpm_pkg::route_hop(item_reg))
                                begin
                                    result_next.status = rtlpm_pkg::STATUS_IDENTICAL;
                                end
                                else
                                begin
                                    ram_we             = 1'b1;
                                    ram_addr           = found_idx_reg;
                                    result_next.status = rtlpm_pkg::STATUS_OK;
                                end
                            end
                            else if (free_reg)
                            begin
                                ram_we                   = 1'b1;
                                ram_addr                 = free_idx_reg;
                                valid_next[free_idx_reg] = 1'b1;
                                result_next.status       = rtlpm_pkg::STATUS_OK;
                            end
                            else
                            begin
                                result_next.status = rtlpm_pkg::STATUS_FULL;
                            end
                        end
                        rtlpm_pkg::OP_DELETE:
                        begin
                            if (found_reg)
                            begin
                                valid_next[found_idx_reg] = 1'b0;
                                result_next.status        = rtlpm_pkg::STATUS_OK;
                            end
                        end
                        rtlpm_pkg::OP_LOOKUP:
                        begin
                            if (best_reg)
                            begin
                                result_next.status  = rtlpm_pkg::STATUS_OK;
                                result_next.hit     = 1'b1;
                                result_next.prefix  = best_word_reg.prefix;
                                result_next.len     = best_word_reg.len;
                                result_next.direct  = best_word_reg.direct;
                                result_next.gateway = best_word_reg.gateway;
                                result_next.iface   = 8'(best_word_reg.iface);
                            end
                        end
                        default:
                        begin
                            result_next.status = rtlpm_pkg::STATUS_NOT_FOUND;
                        end
                    endcase
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and scan findings
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        item_reg       <= item_next;
        rd_idx_reg     <= rd_idx_next;
        pidx_reg       <= pidx_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        found_word_reg <= found_word_next;
        free_reg       <= free_next;
        free_idx_reg   <= free_idx_next;
        best_reg       <= best_next;
        best_word_reg  <= best_word_next;
        result_reg     <= result_next;
    end

    // result transaction
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = result_reg.status;
    assign rsp.hit             = result_reg.hit;
    assign rsp.match_prefix    = result_reg.prefix;
    assign rsp.match_len       = result_reg.len;
    assign rsp.match_direct    = result_reg.direct;
    assign rsp.match_gateway   = result_reg.gateway;
    assign rsp.match_interface = result_reg.iface;

endmodule

// ----- design/rtlpm_ram.sv -----
// generic single-port synchronous ram with registered read
module rtlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one word per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ----- bench/tb_ipv4_route_table_lpm_core.sv -----
// self-checking testbench of the ipv4 longest prefix match route table core
`timescale 1ns / 1ps

module tb_ipv4_route_table_lpm_core;

    // opcode value outside the defined operations
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 80;
    localparam int POOL_MAX    = 160;

    // one request transaction
    typedef struct {
        logic [1:0]  op;
        logic [31:0] addr;
        logic [5:0]  plen;
        logic        direct;
        logic [31:0] gw;
        logic [7:0]  ifc;
    } route_cmd_t;

    logic clk;
    logic rst_n;

    rtlpm_req_if req_ch ();
    rtlpm_rsp_if rsp_ch ();

    ipv4_route_table_lpm_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the route table
    logic              rt_valid  [rtlpm_pkg::TABLE_ENTRIES];
    logic [31:0]       rt_prefix [rtlpm_pkg::TABLE_ENTRIES];
    logic [5:0]        rt_len    [rtlpm_pkg::TABLE_ENTRIES];
    logic              rt_direct [rtlpm_pkg::TABLE_ENTRIES];
    logic [31:0]       rt_gw     [rtlpm_pkg::TABLE_ENTRIES];
    rtlpm_pkg::iface_t rt_ifc    [rtlpm_pkg::TABLE_ENTRIES];

    route_cmd_t         route_cmds[$];
    rtlpm_pkg::result_t pending_results[$];
    route_cmd_t         cur_cmd;

    int errors       = 0;
    int accepted_cnt = 0;
    int total_cmds   = 0;
    int sent_cnt     = 0;
    int results_seen = 0;
    int gap_left;
    int hold_left;
    bit drv_calm     = 0;
    bit rcv_calm     = 0;

    // coverage tallies for the summary
    int n_add = 0, n_del = 0, n_lookup = 0, n_hit = 0;
    int n_full = 0, n_ident = 0, n_replace = 0, n_reserved = 0;

    // address bits kept by a prefix of the given length
    function automatic logic [31:0] prefix_mask(input logic [5:0] l);
        if (l == 6'd0)
            return 32'h0;
        return 32'hFFFF_FFFF << (6'd32 - l);
    endfunction

    // update the shadow table and work out the result of one transaction
    function automatic rtlpm_pkg::result_t apply_route_cmd(input route_cmd_t c);
        rtlpm_pkg::result_t r;
        logic [5:0]         l;
        logic [31:0]        pfx;
        logic               d;
        logic [31:0]        g;
        rtlpm_pkg::iface_t  f;
        int                 slot;
        int                 free_slot;
        int                 best;

        r = '0;
        r.status = rtlpm_pkg::STATUS_NOT_FOUND;
        l = (c.plen > 6'd32) ? 6'd32 : c.plen;
        pfx = c.addr & prefix_mask(l);
        slot = -1;
        free_slot = -1;
        for (int i = 0; i < rtlpm_pkg::TABLE_ENTRIES; i++)
        begin
            if (rt_valid[i] && rt_prefix[i] == pfx && rt_len[i] == l && slot < 0)
                slot = i;
            if (!rt_valid[i] && free_slot < 0)
                free_slot = i;
        end

        case (c.op)
            rtlpm_pkg::OP_ADD:
            begin
                n_add++;
                d = c.direct;
                g = d ? 32'h0 : c.gw;
                f = d ? rtlpm_pkg::iface_t'(0) : rtlpm_pkg::iface_t'(c.ifc);
                if (slot >= 0)
                begin
                    if (rt_direct[slot] == d && rt_gw[slot] == g && rt_ifc[slot] == f)
                    begin
                        r.status = rtlpm_pkg::STATUS_IDENTICAL;
                        n_ident++;
                    end
                    else
                    begin
                        rt_direct[slot] = d;
                        rt_gw[slot]     = g;
                        rt_ifc[slot]    = f;
                        r.status = rtlpm_pkg::STATUS_OK;
                        n_replace++;
                    end
                end
                else if (free_slot < 0)
                begin
                    r.status = rtlpm_pkg::STATUS_FULL;
                    n_full++;
                end
                else
                begin
                    rt_valid[free_slot]  = 1'b1;
                    rt_prefix[free_slot] = pfx;
                    rt_len[free_slot]    = l;
                    rt_direct[free_slot] = d;
                    rt_gw[free_slot]     = g;
                    rt_ifc[free_slot]    = f;
                    r.status = rtlpm_pkg::STATUS_OK;
                end
            end
            rtlpm_pkg::OP_DELETE:
            begin
                n_del++;
                if (slot >= 0)
                begin
                    rt_valid[slot] = 1'b0;
                    r.status = rtlpm_pkg::STATUS_OK;
                end
            end
            rtlpm_pkg::OP_LOOKUP:
            begin
                n_lookup++;
                best = -1;
                for (int i = 0; i < rtlpm_pkg::TABLE_ENTRIES; i++)
                begin
                    if (rt_valid[i] && (c.addr & prefix_mask(rt_len[i])) == rt_prefix[i]
                            && (best < 0 || rt_len[i] > rt_len[best]))
                        best = i;
                end
                if (best >= 0)
                begin
                    n_hit++;
                    r.status  = rtlpm_pkg::STATUS_OK;
                    r.hit     = 1'b1;
                    r.prefix  = rt_prefix[best];
                    r.len     = rt_len[best];
                    r.direct  = rt_direct[best];
                    r.gateway = rt_gw[best];
                    r.iface   = 8'(rt_ifc[best]);
                end
            end
            default:
                n_reserved++;
        endcase
        return r;
    endfunction

    task automatic push_cmd(input logic [1:0] op, input logic [31:0] addr,
                            input logic [5:0] plen, input logic direct,
                            input logic [31:0] gw, input logic [7:0] ifc);
        route_cmd_t c;
        c.op = op;
        c.addr = addr;
        c.plen = plen;
        c.direct = direct;
        c.gw = gw;
        c.ifc = ifc;
        route_cmds.push_back(c);
        total_cmds++;
    endtask

    // the first POOL_MAX routes handed out, reused to reach replace, identical and delete hits
    logic [31:0] pool_addr   [$];
    logic [5:0]  pool_len    [$];
    logic        pool_direct [$];
    logic [31:0] pool_gw     [$];
    logic [7:0]  pool_ifc    [$];

    // random transactions with the given add and delete shares in percent
    task automatic gen_random(input int count, input int add_pct, input int del_pct);
        int          roll;
        int          k;
        logic [31:0] a;
        logic [31:0] m;
        logic [5:0]  l;
        logic        d;
        logic [31:0] g;
        logic [7:0]  f;

        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            k = (pool_addr.size() != 0) ? $urandom_range(0, pool_addr.size() - 1) : -1;
            if (roll < 3)
            begin
                push_cmd(OP_RESERVED, $urandom, 6'($urandom), 1'($urandom), $urandom,
                         8'($urandom));
            end
            else if (roll < 3 + add_pct)
            begin
                d = ($urandom_range(0, 3) == 0);
                g = $urandom;
                f = 8'($urandom_range(0, 255));
                if (k >= 0 && $urandom_range(0, 99) < 35)
                begin
                    // same key again with low bits stirred, same or fresh next hop
                    m = prefix_mask((pool_len[k] > 6'd32) ? 6'd32 : pool_len[k]);
                    a = pool_addr[k] ^ ($urandom & ~m);
                    if ($urandom_range(0, 1) == 0)
                    begin
                        d = pool_direct[k];
                        g = pool_gw[k];
                        f = pool_ifc[k];
                    end
                    else
                    begin
                        pool_direct[k] = d;
                        pool_gw[k] = g;
                        pool_ifc[k] = f;
                    end
                    push_cmd(rtlpm_pkg::OP_ADD, a, pool_len[k], d, g, f);
                end
                else
                begin
                    a = $urandom;
                    l = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(4, 32));
                    if (pool_addr.size() < POOL_MAX)
                    begin
                        pool_addr.push_back(a);
                        pool_len.push_back(l);
                        pool_direct.push_back(d);
                        pool_gw.push_back(g);
                        pool_ifc.push_back(f);
                    end
                    push_cmd(rtlpm_pkg::OP_ADD, a, l, d, g, f);
                end
            end
            else if (roll < 3 + add_pct + del_pct)
            begin
                if (k >= 0 && $urandom_range(0, 99) < 75)
                    push_cmd(rtlpm_pkg::OP_DELETE, pool_addr[k], pool_len[k], 1'($urandom),
                             $urandom, 8'($urandom));
                else
                    push_cmd(rtlpm_pkg::OP_DELETE, $urandom, 6'($urandom_range(0, 63)),
                             1'($urandom), $urandom, 8'($urandom));
            end
            else
            begin
                if (k >= 0 && $urandom_range(0, 99) < 70)
                begin
                    m = prefix_mask((pool_len[k] > 6'd32) ? 6'd32 : pool_len[k]);
                    a = (pool_addr[k] & m) | ($urandom & ~m);
                end
                else
                begin
                    a = $urandom;
                end
                push_cmd(rtlpm_pkg::OP_LOOKUP, a, 6'($urandom), 1'($urandom), $urandom,
                         8'($urandom));
            end
        end
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // request driver: one transaction per handshake, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        route_cmd_t c;
        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.opcode        <= '0;
            req_ch.address       <= '0;
            req_ch.prefix_len    <= '0;
            req_ch.direct        <= 1'b0;
            req_ch.gateway       <= '0;
            req_ch.out_interface <= '0;
            gap_left             <= 0;
            for (int i = 0; i < rtlpm_pkg::TABLE_ENTRIES; i++)
                rt_valid[i] = 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                pending_results.push_back(apply_route_cmd(cur_cmd));
                accepted_cnt++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left     <= gap_left - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (route_cmds.size() != 0)
                begin
                    c = route_cmds.pop_front();
                    cur_cmd = c;
                    req_ch.valid         <= 1'b1;
                    req_ch.opcode        <= c.op;
                    req_ch.address       <= c.addr;
                    req_ch.prefix_len    <= c.plen;
                    req_ch.direct        <= c.direct;
                    req_ch.gateway       <= c.gw;
                    req_ch.out_interface <= c.ifc;
                    if (sent_cnt % 40 == 0)
                        drv_calm = ($urandom_range(0, 2) == 0);
                    gap_left <= drv_calm ? 0 : $urandom_range(0, 13);
                    sent_cnt++;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // result monitor: compare against the oldest prediction, random back-pressure
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        rtlpm_pkg::result_t want;
        int                 hold;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp_ch.status));
                    check_field("hit", 32'(want.hit), 32'(rsp_ch.hit));
                    check_field("match_prefix", want.prefix, rsp_ch.match_prefix);
                    check_field("match_len", 32'(want.len), 32'(rsp_ch.match_len));
                    check_field("match_direct", 32'(want.direct), 32'(rsp_ch.match_direct));
                    check_field("match_gateway", want.gateway, rsp_ch.match_gateway);
                    check_field("match_interface", 32'(want.iface),
                                32'(rsp_ch.match_interface));
                end
                results_seen++;
                if (results_seen % 40 == 0)
                    rcv_calm = ($urandom_range(0, 2) == 0);
                // one long hold so the core backs up and stalls its input
                if (results_seen == 120)
                    hold = LONG_HOLD;
                else
                    hold = rcv_calm ? 0 : $urandom_range(0, 13);
                hold_left    <= hold;
                rsp_ch.ready <= (hold == 0);
            end
            else if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                rsp_ch.ready <= (hold_left == 1);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // reset, stimulus and end of run
    initial
    begin
        rst_n = 1'b0;

        // directed: empty table, default route, host routes, masking,
        // identical and replace, saturated length, reserved opcode
        push_cmd(rtlpm_pkg::OP_LOOKUP, 32'h0A00_0001, 6'd0, 1'b0, 32'h0, 8'h0);
        push_cmd(rtlpm_pkg::OP_ADD, 32'h0000_0000, 6'd0, 1'b0, 32'h0A00_0001, 8'h01);
        push_cmd(rtlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 8'h0);
        push_cmd(rtlpm_pkg::OP_ADD, 32'hFFFF_FFFF, 6'd32, 1'b1, 32'hFFFF_FFFF, 8'hFF);
        push_cmd(rtlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 8'h0);
        push_cmd(rtlpm_pkg::OP_ADD, 32'h0A0B_0C0D, 6'd8, 1'b0, 32'hC0A8_0001, 8'h02);
        push_cmd(rtlpm_pkg::OP_ADD, 32'h0A0B_0000, 6'd16, 1'b0, 32'hC0A8_0002, 8'h03);
        push_cmd(rtlpm_pkg::OP_LOOKUP, 32'h0A0B_0C0D, 6'd0, 1'b0, 32'h0, 8'h0);
        push_cmd(rtlpm_pkg::OP_ADD, 32'h0A77_7777, 6'd8, 1'b0, 32'hC0A8_0001, 8'h02);
        push_cmd(rtlpm_pkg::OP_ADD, 32'h0A00_0000, 6'd8, 1'b0, 32'hC0A8_0009, 8'h04);
        push_cmd(rtlpm_pkg::OP_LOOKUP, 32'h0A99_0000, 6'd0, 1'b0, 32'h0, 8'h0);
        push_cmd(rtlpm_pkg::OP_ADD, 32'h1234_5678, 6'd40, 1'b0, 32'h8000_0001, 8'h80);
        push_cmd(rtlpm_pkg::OP_LOOKUP, 32'h1234_5678, 6'd0, 1'b0, 32'h0, 8'h0);
        push_cmd(rtlpm_pkg::OP_DELETE, 32'h1234_5678, 6'd63, 1'b0, 32'h0, 8'h0);
        push_cmd(rtlpm_pkg::OP_DELETE, 32'h1234_5678, 6'd32, 1'b0, 32'h0, 8'h0);
        push_cmd(OP_RESERVED, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 8'hFF);
        push_cmd(rtlpm_pkg::OP_LOOKUP, 32'h0A0B_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 8'hFF);
        push_cmd(rtlpm_pkg::OP_DELETE, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 8'h0);
        push_cmd(rtlpm_pkg::OP_LOOKUP, 32'h0102_0304, 6'd0, 1'b0, 32'h0, 8'h0);
        push_cmd(rtlpm_pkg::OP_ADD, 32'h8000_0000, 6'd1, 1'b0, 32'hFFFF_FFFF, 8'hFF);
        push_cmd(rtlpm_pkg::OP_LOOKUP, 32'hFFFF_0000, 6'd0, 1'b0, 32'h0, 8'h0);
        push_cmd(rtlpm_pkg::OP_ADD, 32'hFFFF_FFFF, 6'd0, 1'b1, 32'h1234_5678, 8'h55);
        push_cmd(rtlpm_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 6'd0, 1'b0, 32'h0, 8'h0);

        // random: fill past capacity, then a mixed stretch, then drain by deletes
        gen_random(160, 85, 5);
        gen_random(380, 40, 20);
        gen_random(210, 20, 40);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_cnt < total_cmds || pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end

        $display("covered %0d transactions: %0d adds, %0d deletes, %0d lookups (%0d hits)",
                 accepted_cnt, n_add, n_del, n_lookup, n_hit);
        $display("adds: %0d replaced, %0d identical, %0d table full; %0d reserved opcodes",
                 n_replace, n_ident, n_full, n_reserved);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- ipv4_route_table_lpm_core.f -----
design/rtlpm_pkg.sv
design/rtlpm_req_if.sv
design/rtlpm_rsp_if.sv
design/rtlpm_ram.sv
design/ipv4_route_table_lpm_core.sv
bench/tb_ipv4_route_table_lpm_core.sv
